>>> design/button_press_classifier_assert.svh
// Assertion macros for the button press classifier.
// Define NO_ASSERTIONS to compile them out; users need clk_i and rst_ni in scope.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BPC_ASSERT(lbl, prop, msg)
`define BPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> design/bpc_pkg.sv
// Shared types and constants for the button press classifier.
// No dependencies; imported by bpc_core and button_press_classifier.
`timescale 1ns / 1ps

package bpc_pkg;

  // Default press/gap counter width
  localparam int unsigned CountWidthDef = 16;

  // Register file: 4 registers, 32-bit words
  localparam int unsigned RegAddrWidth = 4;
  localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [1:0] REG_SHORT_TICKS  = 2'd1;
  localparam logic [1:0] REG_LONG_TICKS   = 2'd2;
  localparam logic [1:0] REG_DOUBLE_WIN   = 2'd3;

  // Reset values of the configuration registers
  localparam logic        ActiveLevelRst = 1'b0;
  localparam logic [15:0] ShortTicksRst  = 16'd5;
  localparam logic [15:0] LongTicksRst   = 16'd500;
  localparam logic [15:0] DoubleWinRst   = 16'd30;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_LONG    = 3'd1,
    EV_SHORT   = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_IGNORED = 3'd4,
    EV_ERROR   = 3'd5
  } event_e;

  typedef struct packed {
    logic        active_level;
    logic [15:0] short_ticks;
    logic [15:0] long_ticks;
    logic [15:0] double_window_ticks;
  } cfg_t;

endpackage

>>> design/bpc_core.sv
// Per-sample classification logic: next counter values and the event code.
// Purely combinational; depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_core import bpc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                   level_i,
  input  cfg_t                   cfg_i,
  input  logic [COUNT_WIDTH-1:0] press_i,
  input  logic [COUNT_WIDTH-1:0] gap_i,
  output logic [COUNT_WIDTH-1:0] press_o,
  output logic [COUNT_WIDTH-1:0] gap_o,
  output event_e                 event_o
);

  // Compare width covers both the counters and the 16-bit registers
  localparam int unsigned CmpWidth = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [CmpWidth-1:0]    press_x, gap_x, short_x, long_x, win_x, half_x, max_x;
  logic [COUNT_WIDTH-1:0] cnt_max, win_clamp, gap_sel;
  logic                   press_max;

  assign cnt_max   = {COUNT_WIDTH{1'b1}};
  assign press_max = &press_i;

  assign press_x = CmpWidth'(press_i);
  assign gap_x   = CmpWidth'(gap_i);
  assign short_x = CmpWidth'(cfg_i.short_ticks);
  assign long_x  = CmpWidth'(cfg_i.long_ticks);
  assign win_x   = CmpWidth'(cfg_i.double_window_ticks);
  assign half_x  = CmpWidth'(cfg_i.short_ticks[15:1]);
  assign max_x   = CmpWidth'(cnt_max);

  // Window loaded into the gap counter, clamped to counter range
  assign win_clamp = (win_x > max_x) ? cnt_max : win_x[COUNT_WIDTH-1:0];

  // Press counting while held, classification on release
  always_comb begin
    event_o = EV_NONE;
    gap_sel = gap_i;
    press_o = '0;
    if (level_i == cfg_i.active_level) begin
      if (press_x == long_x && !press_max) begin
        event_o = EV_LONG;
      end
      press_o = press_max ? press_i : press_i + COUNT_WIDTH'(1);
    end else if (press_x != '0) begin
      priority if (press_x >= long_x) begin
        gap_sel = '0;
      end else if (press_x >= short_x) begin
        if (gap_x < win_x) begin
          event_o = (gap_x > half_x) ? EV_DOUBLE : EV_IGNORED;
          gap_sel = win_clamp;
        end else begin
          event_o = EV_SHORT;
          gap_sel = '0;
        end
      end else begin
        event_o = EV_ERROR;
      end
    end
  end

  // Gap advances by one tick from the selected value (held, cleared or window), saturating
  assign gap_o = (&gap_sel) ? gap_sel : gap_sel + COUNT_WIDTH'(1);

endmodule

>>> design/button_press_classifier.sv
// Button press classifier: result valid in the cycle after the input transfer.
// Throughput 1 sample per cycle; the result register holds one item and the
// input is taken whenever that register is empty or being drained.
// Reset (rst_ni low, asynchronous) clears both counters, the result valid flag
// and loads the configuration registers with their defaults.
// Depends on bpc_pkg, bpc_core and button_press_classifier_assert.svh.
`timescale 1ns / 1ps
`include "button_press_classifier_assert.svh"

module button_press_classifier import bpc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // APB-style configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [RegAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Sample input
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    level_i,
  // Event output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              event_res_o
);

  cfg_t                   cfg_q;
  logic [COUNT_WIDTH-1:0] press_q, press_d, gap_q, gap_d;
  event_e                 event_d, event_q;
  logic                   out_valid_q;
  logic                   in_xfer, cfg_wr;
  logic [1:0]             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[RegAddrWidth-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level        <= ActiveLevelRst;
      cfg_q.short_ticks         <= ShortTicksRst;
      cfg_q.long_ticks          <= LongTicksRst;
      cfg_q.double_window_ticks <= DoubleWinRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ACTIVE_LEVEL: cfg_q.active_level        <= pwdata[0];
        REG_SHORT_TICKS:  cfg_q.short_ticks         <= pwdata[15:0];
        REG_LONG_TICKS:   cfg_q.long_ticks          <= pwdata[15:0];
        REG_DOUBLE_WIN:   cfg_q.double_window_ticks <= pwdata[15:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_LEVEL: prdata = {31'd0, cfg_q.active_level};
      REG_SHORT_TICKS:  prdata = {16'd0, cfg_q.short_ticks};
      REG_LONG_TICKS:   prdata = {16'd0, cfg_q.long_ticks};
      REG_DOUBLE_WIN:   prdata = {16'd0, cfg_q.double_window_ticks};
    endcase
  end

  // Handshake: take a sample when the result slot is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  bpc_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .level_i (level_i),
    .cfg_i   (cfg_q),
    .press_i (press_q),
    .gap_i   (gap_q),
    .press_o (press_d),
    .gap_o   (gap_d),
    .event_o (event_d)
  );

  // Counter state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q     <= '0;
      gap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        press_q <= press_d;
        gap_q   <= gap_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      event_q <= event_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = 3'(event_q);

  // Checks
  `BPC_ASSERT(a_result_follows, in_xfer |=> out_valid_o, "result missing after transfer")
  `BPC_ASSERT(a_gap_nonzero, in_xfer |=> (gap_q != '0), "idle gap not advanced")
  `BPC_ASSERT(a_held_no_release_ev,
    (in_xfer && level_i == cfg_q.active_level) |=> (event_q == EV_NONE || event_q == EV_LONG),
    "release event while held")
  `BPC_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_q |-> in_ready_o, "input stalled with empty slot")

endmodule
